FILE: rtl/core/nntk_pkg.sv
// shared types, widths and codes for the k-nearest-neighbor search block
package nntk_pkg;

    localparam int MAX_DIMS_DEF    = 64;
    localparam int MAX_K_DEF       = 16;
    localparam int MAX_VECTORS_DEF = 1048576;

    localparam int ACTION_W   = 2;
    localparam int ELEM_W     = 16;
    localparam int INDEX_W    = 20;
    localparam int OUT_DIST_W = 38;
    localparam int DIST_W     = 39;
    localparam int RANK_W     = 4;
    localparam int DIMS_W     = 7;
    localparam int KCFG_W     = 5;
    localparam int SQ_W       = 2 * ELEM_W;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DIMS_IN_USE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_K_IN_USE    = 2'd1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_QUERY    = 2'd0,
        ACT_DATABASE = 2'd1,
        ACT_FINISH   = 2'd2
    } action_t;

    // controller to datapath
    typedef struct packed {
        logic query_write;
        logic diff;
        logic square;
        logic accum;
        logic insert;
        logic finish;
        logic out_load;
        logic out_first;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic vec_end;
        logic has_room;
        logic out_last;
    } status_t;

endpackage

FILE: rtl/core/nntk_if.sv
// valid/ready channel interfaces for input items, results and configuration writes
interface nntk_in_if;
    logic                                valid;
    logic                                ready;
    logic [nntk_pkg::ACTION_W-1:0]       action;
    logic signed [nntk_pkg::ELEM_W-1:0]  element_value;

    modport source (output valid, output action, output element_value, input ready);
    modport sink   (input valid, input action, input element_value, output ready);
endinterface

interface nntk_out_if;
    logic                                valid;
    logic                                ready;
    logic [nntk_pkg::INDEX_W-1:0]        neighbor_index;
    logic [nntk_pkg::OUT_DIST_W-1:0]     neighbor_distance;
    logic [nntk_pkg::RANK_W-1:0]         neighbor_rank;
    logic                                result_valid;
    logic                                last_result;

    modport source (output valid, output neighbor_index, output neighbor_distance,
                    output neighbor_rank, output result_valid, output last_result,
                    input ready);
    modport sink   (input valid, input neighbor_index, input neighbor_distance,
                    input neighbor_rank, input result_valid, input last_result,
                    output ready);
endinterface

interface nntk_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [nntk_pkg::CFG_IDX_W-1:0]      index;
    logic [nntk_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/nntk_ctrl.sv
// sequencing state machine for the k-nearest-neighbor search block
module nntk_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_fire,
    input  logic [nntk_pkg::ACTION_W-1:0]  in_action,
    input  logic                           out_fire,
    input  nntk_pkg::status_t              status,
    output nntk_pkg::cmd_t                 cmd,
    output logic                           in_ready,
    output logic                           out_valid
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_QUERY,
        ST_DIFF,
        ST_SQUARE,
        ST_ACCUM,
        ST_INSERT,
        ST_FINISH,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_ready_reg;
    logic   out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (in_action)
                        nntk_pkg::ACT_QUERY:    state_next = ST_QUERY;
                        nntk_pkg::ACT_DATABASE: state_next = ST_DIFF;
                        nntk_pkg::ACT_FINISH:   state_next = ST_FINISH;
                        default:                state_next = ST_IDLE;
                    endcase
                end
            end
            ST_QUERY:  state_next = ST_IDLE;
            ST_DIFF:   state_next = ST_SQUARE;
            ST_SQUARE: state_next = ST_ACCUM;
            ST_ACCUM:
            begin
                if (status.vec_end && status.has_room)
                    state_next = ST_INSERT;
                else
                    state_next = ST_IDLE;
            end
            ST_INSERT: state_next = ST_IDLE;
            ST_FINISH: state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (out_fire && status.out_last)
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_QUERY:  cmd.query_write = 1'b1;
            ST_DIFF:   cmd.diff        = 1'b1;
            ST_SQUARE: cmd.square      = 1'b1;
            ST_ACCUM:  cmd.accum       = 1'b1;
            ST_INSERT: cmd.insert      = 1'b1;
            ST_FINISH:
            begin
                cmd.finish    = 1'b1;
                cmd.out_load  = 1'b1;
                cmd.out_first = 1'b1;
            end
            ST_EMIT:   cmd.out_load = out_fire && !status.out_last;
            default:   cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            in_ready_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_ready_reg  <= (state_next == ST_IDLE);
            out_valid_reg <= (state_next == ST_EMIT);
        end
    end

    assign in_ready  = in_ready_reg;
    assign out_valid = out_valid_reg;

endmodule

FILE: rtl/core/nntk_dp.sv
// datapath: query memory, distance pipeline, sorted top-k cells and result register
module nntk_dp #(
    parameter int MAX_DIMS    = nntk_pkg::MAX_DIMS_DEF,
    parameter int MAX_K       = nntk_pkg::MAX_K_DEF,
    parameter int MAX_VECTORS = nntk_pkg::MAX_VECTORS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_fire,
    input  logic signed [nntk_pkg::ELEM_W-1:0]   in_element,
    input  logic                                 cfg_fire,
    input  logic [nntk_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [nntk_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  nntk_pkg::cmd_t                       cmd,
    output nntk_pkg::status_t                    status,
    output logic [nntk_pkg::INDEX_W-1:0]         neighbor_index,
    output logic [nntk_pkg::OUT_DIST_W-1:0]      neighbor_distance,
    output logic [nntk_pkg::RANK_W-1:0]          neighbor_rank,
    output logic                                 result_valid,
    output logic                                 last_result
);

    localparam int POS_W  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int KI_W   = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int FILL_W = $clog2(MAX_K + 1);
    localparam int CNT_W  = $clog2(MAX_VECTORS + 1);
    localparam int DW     = nntk_pkg::DIST_W;
    localparam int IW     = nntk_pkg::INDEX_W;

    // configuration
    logic [nntk_pkg::DIMS_W-1:0] dims_reg;
    logic [nntk_pkg::KCFG_W-1:0] k_reg;
    logic [nntk_pkg::DIMS_W-1:0] dims_eff;
    logic [nntk_pkg::KCFG_W-1:0] k_clamp;
    logic [FILL_W-1:0]           k_eff;

    // element path
    logic signed [nntk_pkg::ELEM_W-1:0] qmem [MAX_DIMS];
    logic signed [nntk_pkg::ELEM_W-1:0] elem_reg;
    logic signed [nntk_pkg::ELEM_W-1:0] q_rd_reg;
    logic signed [nntk_pkg::ELEM_W:0]   diff;
    logic [nntk_pkg::ELEM_W-1:0]        mag_reg;
    logic [nntk_pkg::SQ_W-1:0]          sq_reg;
    logic [DW-1:0]                      acc_reg;
    logic [DW-1:0]                      sum;
    logic [DW-1:0]                      new_dist_reg;
    logic [POS_W-1:0]                   pos_reg;
    logic [nntk_pkg::DIMS_W-1:0]        pos_plus;
    logic [POS_W-1:0]                   pos_adv;
    logic [CNT_W-1:0]                   count_reg;
    logic                               has_room;

    // top-k cells
    logic [DW-1:0]     best_dist [MAX_K];
    logic [IW-1:0]     best_idx  [MAX_K];
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_eff;
    logic [MAX_K-1:0]  goes_ahead;
    logic [MAX_K-1:0]  hit;
    logic              accept_new;
    logic [IW-1:0]     new_idx;

    // result register
    logic [IW-1:0]                   out_index_reg;
    logic [nntk_pkg::OUT_DIST_W-1:0] out_dist_reg;
    logic [nntk_pkg::RANK_W-1:0]     out_rank_reg;
    logic                            out_valid_flag_reg;
    logic                            out_last_reg;
    logic [nntk_pkg::RANK_W-1:0]     sel_rank;
    logic [KI_W-1:0]                 sel_idx;
    logic                            list_empty;

    always_comb
    begin
        if (dims_reg == '0)
            dims_eff = nntk_pkg::DIMS_W'(1);
        else if (dims_reg > nntk_pkg::DIMS_W'(MAX_DIMS))
            dims_eff = nntk_pkg::DIMS_W'(MAX_DIMS);
        else
            dims_eff = dims_reg;

        if (k_reg == '0)
            k_clamp = nntk_pkg::KCFG_W'(1);
        else if (k_reg > nntk_pkg::KCFG_W'(MAX_K))
            k_clamp = nntk_pkg::KCFG_W'(MAX_K);
        else
            k_clamp = k_reg;
        k_eff = FILL_W'(k_clamp);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dims_reg <= nntk_pkg::DIMS_W'(64);
            k_reg    <= nntk_pkg::KCFG_W'(10);
        end
        else if (cfg_fire)
        begin
            case (cfg_index)
                nntk_pkg::CFG_DIMS_IN_USE: dims_reg <= cfg_data[nntk_pkg::DIMS_W-1:0];
                nntk_pkg::CFG_K_IN_USE:    k_reg    <= cfg_data[nntk_pkg::KCFG_W-1:0];
                default:                   ;
            endcase
        end
    end

    // position wraps after the last dimension
    assign pos_plus = nntk_pkg::DIMS_W'(pos_reg) + nntk_pkg::DIMS_W'(1);
    assign pos_adv  = (pos_plus >= dims_eff) ? '0 : POS_W'(pos_plus);

    assign diff     = {elem_reg[nntk_pkg::ELEM_W-1], elem_reg}
                    - {q_rd_reg[nntk_pkg::ELEM_W-1], q_rd_reg};
    assign sum      = acc_reg + DW'(sq_reg);
    assign has_room = (count_reg < CNT_W'(MAX_VECTORS));
    assign new_idx  = IW'(count_reg);

    // query memory: written on a query element, read on every accepted item
    always_ff @(posedge clk)
    begin
        if (cmd.query_write)
            qmem[pos_reg] <= elem_reg;
        if (in_fire)
        begin
            q_rd_reg <= qmem[pos_reg];
            elem_reg <= in_element;
        end
        if (cmd.diff)
            mag_reg <= nntk_pkg::ELEM_W'(diff[nntk_pkg::ELEM_W] ? -diff : diff);
        if (cmd.square)
            sq_reg <= {{nntk_pkg::ELEM_W{1'b0}}, mag_reg}
                    * {{nntk_pkg::ELEM_W{1'b0}}, mag_reg};
        if (cmd.accum)
            new_dist_reg <= sum;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            acc_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (cmd.query_write)
            begin
                pos_reg   <= pos_adv;
                acc_reg   <= '0;
                count_reg <= '0;
            end
            else if (cmd.accum)
            begin
                pos_reg <= pos_adv;
                acc_reg <= (pos_adv == '0) ? '0 : sum;
            end
            else if (cmd.insert)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (cmd.finish)
            begin
                pos_reg <= '0;
                acc_reg <= '0;
            end
        end
    end

    // compare-and-shift cells, ties keep the earlier vector in front
    assign fill_eff = (fill_reg < k_eff) ? fill_reg : k_eff;

    always_comb
    begin
        for (int i = 0; i < MAX_K; i++)
        begin
            goes_ahead[i] = (FILL_W'(i) >= fill_eff) || (new_dist_reg < best_dist[i]);
            hit[i]        = goes_ahead[i] && (FILL_W'(i) < k_eff);
        end
    end

    assign accept_new = |hit;

    for (genvar g = 0; g < MAX_K; g++)
    begin : g_cell
        always_ff @(posedge clk)
        begin
            if (cmd.insert)
            begin
                if (g > 0 && goes_ahead[(g > 0) ? g - 1 : 0])
                begin
                    best_dist[g] <= best_dist[(g > 0) ? g - 1 : 0];
                    best_idx[g]  <= best_idx[(g > 0) ? g - 1 : 0];
                end
                else if (goes_ahead[g])
                begin
                    best_dist[g] <= new_dist_reg;
                    best_idx[g]  <= new_idx;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_reg <= '0;
        else if (cmd.query_write)
            fill_reg <= '0;
        else if (cmd.insert)
        begin
            if (accept_new && fill_eff < k_eff)
                fill_reg <= fill_eff + FILL_W'(1);
            else
                fill_reg <= fill_eff;
        end
    end

    // result register, one list entry per output transaction
    assign list_empty = (fill_eff == '0);
    assign sel_rank   = cmd.out_first ? '0 : out_rank_reg + nntk_pkg::RANK_W'(1);
    assign sel_idx    = KI_W'(sel_rank);

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            if (list_empty)
            begin
                out_index_reg      <= '0;
                out_dist_reg       <= '0;
                out_rank_reg       <= '0;
                out_valid_flag_reg <= 1'b0;
                out_last_reg       <= 1'b1;
            end
            else
            begin
                out_index_reg      <= best_idx[sel_idx];
                out_dist_reg       <= best_dist[sel_idx][nntk_pkg::OUT_DIST_W-1:0];
                out_rank_reg       <= sel_rank;
                out_valid_flag_reg <= 1'b1;
                out_last_reg       <= (nntk_pkg::KCFG_W'(sel_rank) + nntk_pkg::KCFG_W'(1)
                                       == nntk_pkg::KCFG_W'(fill_eff));
            end
        end
    end

    assign status.vec_end  = (pos_adv == '0);
    assign status.has_room = has_room;
    assign status.out_last = out_last_reg;

    assign neighbor_index    = out_index_reg;
    assign neighbor_distance = out_dist_reg;
    assign neighbor_rank     = out_rank_reg;
    assign result_valid      = out_valid_flag_reg;
    assign last_result       = out_last_reg;

endmodule

FILE: rtl/core/nearest_neighbor_topk_l2_top.sv
// top level of the brute-force k-nearest-neighbor search under squared l2 distance
//
// query elements and database elements arrive one per input transaction and share
// one position counter; a query element stores its value and clears the neighbor
// list, a database element adds its squared difference to the running distance, and
// the element that closes a vector drops that vector into a sorted list of the best
// k (equal distances keep the earlier vector first). a finish transaction sends the
// list out nearest first, one output transaction per neighbor with the last one
// marked, or a single result with result_valid low when no vector was kept. the
// block works on one item at a time: a query element is written to query memory,
// a database element passes through the registered query memory read, difference,
// 16x16 square and 39-bit accumulate steps, and one that closes a vector below the
// capacity limit also through the parallel compare-and-shift cells; a finish sends
// one result per output transaction while the output side takes them.
// configuration writes are always taken and apply at once; write them only while idle.
module nearest_neighbor_topk_l2_top #(
    parameter int MAX_DIMS    = nntk_pkg::MAX_DIMS_DEF,
    parameter int MAX_K       = nntk_pkg::MAX_K_DEF,
    parameter int MAX_VECTORS = nntk_pkg::MAX_VECTORS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    nntk_in_if.sink     in_ch,
    nntk_out_if.source  out_ch,
    nntk_cfg_if.sink    cfg
);

    nntk_pkg::cmd_t    cmd;
    nntk_pkg::status_t status;
    logic              in_fire;
    logic              out_fire;
    logic              cfg_fire;

    // transaction strobes for each channel
    assign in_fire  = in_ch.valid && in_ch.ready;
    assign out_fire = out_ch.valid && out_ch.ready;
    assign cfg_fire = cfg.valid && cfg.ready;

    // register writes never stall
    assign cfg.ready = 1'b1;

    // sequencer: owns input ready and output valid
    nntk_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .in_action (in_ch.action),
        .out_fire  (out_fire),
        .status    (status),
        .cmd       (cmd),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid)
    );

    // datapath: distances, top-k list and the result payload
    nntk_dp #(
        .MAX_DIMS    (MAX_DIMS),
        .MAX_K       (MAX_K),
        .MAX_VECTORS (MAX_VECTORS)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_fire           (in_fire),
        .in_element        (in_ch.element_value),
        .cfg_fire          (cfg_fire),
        .cfg_index         (cfg.index),
        .cfg_data          (cfg.data),
        .cmd               (cmd),
        .status            (status),
        .neighbor_index    (out_ch.neighbor_index),
        .neighbor_distance (out_ch.neighbor_distance),
        .neighbor_rank     (out_ch.neighbor_rank),
        .result_valid      (out_ch.result_valid),
        .last_result       (out_ch.last_result)
    );

endmodule

FILE: rtl/core/nntk_checker.sv
// port-level assertions for the k-nearest-neighbor search block, bound to the top level
module nntk_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  logic [nntk_pkg::ACTION_W-1:0]     in_action,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic [nntk_pkg::INDEX_W-1:0]      out_index,
    input  logic [nntk_pkg::OUT_DIST_W-1:0]   out_distance,
    input  logic [nntk_pkg::RANK_W-1:0]       out_rank,
    input  logic                              out_result_valid,
    input  logic                              out_last
);

    // one item at a time: no new input while results are pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid)
        else $error("input ready while a result is pending");

    // a finish transaction shows its first result once the controller has passed its finish state
    a_finish_emits: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_action == nntk_pkg::ACT_FINISH |=> ##1 out_valid)
        else $error("finish gave no result");

    // ranks of one run count up without gaps
    a_rank_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_last
        |=> out_valid && out_rank == $past(out_rank) + nntk_pkg::RANK_W'(1))
        else $error("rank sequence broken");

    // the empty-list result stands alone
    a_empty_alone: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_result_valid |-> out_last && out_rank == '0)
        else $error("empty result not marked last at rank zero");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_index)
        && $stable(out_distance) && $stable(out_rank) && $stable(out_last))
        else $error("stalled result changed");

endmodule

bind nearest_neighbor_topk_l2_top nntk_checker u_nntk_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_ch.valid),
    .in_ready         (in_ch.ready),
    .in_action        (in_ch.action),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_index        (out_ch.neighbor_index),
    .out_distance     (out_ch.neighbor_distance),
    .out_rank         (out_ch.neighbor_rank),
    .out_result_valid (out_ch.result_valid),
    .out_last         (out_ch.last_result)
);

FILE: sim/tb.sv
`timescale 1ns / 100ps
// self-checking testbench for the brute-force k-nearest-neighbor search block
module tb;

    // action code that the block must ignore
    localparam logic [nntk_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;
    // idle cycles after the last result
    localparam int SETTLE_CYCLES = 12;
    // cycles without any transaction before the run is declared hung
    localparam int STALL_LIMIT = 5000;

    typedef struct {
        logic [nntk_pkg::INDEX_W-1:0]    index;
        logic [nntk_pkg::OUT_DIST_W-1:0] span;
        logic [nntk_pkg::RANK_W-1:0]     rank;
        logic                            valid;
        logic                            is_last;
    } neighbor_t;

    logic clk = 1'b0;
    logic rst_n;

    nntk_in_if  in_ch();
    nntk_out_if out_ch();
    nntk_cfg_if cfg();

    nearest_neighbor_topk_l2_top u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg)
    );

    // 8 ns period
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // neighbor lists still to come out, oldest first
    neighbor_t pending_neighbors[$];

    int failures      = 0;
    int items_sent    = 0;
    int quiet_cycles  = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // ------------------------------------------------------------------
    // predictor: own copy of the registers and the search state
    // ------------------------------------------------------------------
    logic [nntk_pkg::DIMS_W-1:0]        dims_reg;
    logic [nntk_pkg::KCFG_W-1:0]        k_reg;
    logic signed [nntk_pkg::ELEM_W-1:0] query_mem [nntk_pkg::MAX_DIMS_DEF];
    logic [nntk_pkg::DIMS_W-1:0]        elem_pos;
    logic [nntk_pkg::DIST_W-1:0]        dist_sum;
    logic [nntk_pkg::INDEX_W:0]         vec_count;
    logic [nntk_pkg::DIST_W-1:0]        top_dist [nntk_pkg::MAX_K_DEF];
    logic [nntk_pkg::INDEX_W-1:0]       top_index [nntk_pkg::MAX_K_DEF];
    logic [nntk_pkg::KCFG_W-1:0]        top_fill;

    // out-of-range register values fold onto the nearest legal one
    function automatic int active_dims();
        if (dims_reg == 0)
            return 1;
        if (dims_reg > nntk_pkg::MAX_DIMS_DEF)
            return nntk_pkg::MAX_DIMS_DEF;
        return dims_reg;
    endfunction

    function automatic int active_k();
        if (k_reg == 0)
            return 1;
        if (k_reg > nntk_pkg::MAX_K_DEF)
            return nntk_pkg::MAX_K_DEF;
        return k_reg;
    endfunction

    // shared element counter, wraps after the last dimension
    function automatic logic [nntk_pkg::DIMS_W-1:0] next_position();
        int nxt;
        nxt = elem_pos + 1;
        return (nxt >= active_dims()) ? '0 : nntk_pkg::DIMS_W'(nxt);
    endfunction

    // sorted insert; equal distances keep the earlier vector in front
    function automatic void insert_neighbor(logic [nntk_pkg::DIST_W-1:0] sq_dist,
                                            logic [nntk_pkg::INDEX_W-1:0] idx);
        int k;
        int fill;
        int slot;
        int i;
        k    = active_k();
        fill = (top_fill < k) ? top_fill : k;
        slot = 0;
        while (slot < fill && top_dist[slot] <= sq_dist)
            slot++;
        if (slot >= k)
        begin
            top_fill = nntk_pkg::KCFG_W'(fill);
            return;
        end
        i = (fill < k) ? fill : k - 1;
        while (i > slot)
        begin
            top_dist[i]  = top_dist[i-1];
            top_index[i] = top_index[i-1];
            i--;
        end
        top_dist[slot]  = sq_dist;
        top_index[slot] = idx;
        top_fill = nntk_pkg::KCFG_W'((fill < k) ? fill + 1 : k);
    endfunction

    // advance the state by one accepted item and queue what it will emit
    function automatic void predict_item(logic [nntk_pkg::ACTION_W-1:0] act,
                                         logic signed [nntk_pkg::ELEM_W-1:0] value);
        logic signed [nntk_pkg::ELEM_W:0]   diff;
        logic signed [nntk_pkg::ELEM_W-1:0] q;
        logic [nntk_pkg::SQ_W-1:0]          mag;
        logic [nntk_pkg::DIST_W-1:0]        sum;
        logic [nntk_pkg::DIMS_W-1:0]        nxt;
        int                                 n;
        neighbor_t                          nb;
        case (act)
            nntk_pkg::ACT_QUERY:
            begin
                top_fill  = '0;
                vec_count = '0;
                dist_sum  = '0;
                if (elem_pos < nntk_pkg::MAX_DIMS_DEF)
                    query_mem[elem_pos] = value;
                elem_pos = next_position();
            end
            nntk_pkg::ACT_DATABASE:
            begin
                q    = (elem_pos < nntk_pkg::MAX_DIMS_DEF) ? query_mem[elem_pos] : '0;
                diff = value - q;
                mag  = (diff < 0) ? nntk_pkg::SQ_W'(-diff) : nntk_pkg::SQ_W'(diff);
                sum  = dist_sum + nntk_pkg::DIST_W'(mag) * nntk_pkg::DIST_W'(mag);
                nxt  = next_position();
                if (nxt == 0)
                begin
                    // vector complete; beyond capacity it is dropped
                    if (vec_count < nntk_pkg::MAX_VECTORS_DEF)
                    begin
                        insert_neighbor(sum, vec_count[nntk_pkg::INDEX_W-1:0]);
                        vec_count++;
                    end
                    dist_sum = '0;
                end
                else
                    dist_sum = sum;
                elem_pos = nxt;
            end
            nntk_pkg::ACT_FINISH:
            begin
                n = (top_fill < active_k()) ? top_fill : active_k();
                // partial vector is thrown away, the list is kept
                elem_pos = '0;
                dist_sum = '0;
                if (n == 0)
                begin
                    nb = '{index: '0, span: '0, rank: '0, valid: 1'b0, is_last: 1'b1};
                    pending_neighbors.push_back(nb);
                end
                for (int r = 0; r < n; r++)
                begin
                    nb.index   = top_index[r];
                    nb.span    = top_dist[r][nntk_pkg::OUT_DIST_W-1:0];
                    nb.rank    = nntk_pkg::RANK_W'(r);
                    nb.valid   = 1'b1;
                    nb.is_last = (r + 1 == n);
                    pending_neighbors.push_back(nb);
                end
            end
            default:
            begin
                // unused action: no state change, nothing emitted
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // result side: random backpressure and the scoreboard
    // ------------------------------------------------------------------
    always @(negedge clk)
        out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    always @(posedge clk)
    begin : check_neighbors
        neighbor_t exp_nb;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_neighbors.size() == 0)
            begin
                $error("unexpected result: neighbor_index %0d neighbor_distance %0d",
                       out_ch.neighbor_index, out_ch.neighbor_distance);
                failures++;
            end
            else
            begin
                exp_nb = pending_neighbors.pop_front();
                if (out_ch.neighbor_index !== exp_nb.index)
                begin
                    $error("neighbor_index: expected %0d, actual %0d",
                           exp_nb.index, out_ch.neighbor_index);
                    failures++;
                end
                if (out_ch.neighbor_distance !== exp_nb.span)
                begin
                    $error("neighbor_distance: expected %0d, actual %0d",
                           exp_nb.span, out_ch.neighbor_distance);
                    failures++;
                end
                if (out_ch.neighbor_rank !== exp_nb.rank)
                begin
                    $error("neighbor_rank: expected %0d, actual %0d",
                           exp_nb.rank, out_ch.neighbor_rank);
                    failures++;
                end
                if (out_ch.result_valid !== exp_nb.valid)
                begin
                    $error("result_valid: expected %0b, actual %0b",
                           exp_nb.valid, out_ch.result_valid);
                    failures++;
                end
                if (out_ch.last_result !== exp_nb.is_last)
                begin
                    $error("last_result: expected %0b, actual %0b",
                           exp_nb.is_last, out_ch.last_result);
                    failures++;
                end
            end
        end
    end

    // hang detector: any transaction on any channel restarts the count
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg.valid && cfg.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // one input transaction; valid stays high on return so back-to-back items
    // run without a gap, stop_items lowers it
    task automatic send_item(logic [nntk_pkg::ACTION_W-1:0] act,
                             logic signed [nntk_pkg::ELEM_W-1:0] value);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.action        <= act;
        in_ch.element_value <= value;
        do
            @(posedge clk);
        while (!in_ch.ready);
        predict_item(act, value);
        if (act != ACT_UNUSED)
            items_sent++;
    endtask

    task automatic stop_items();
        @(negedge clk);
        in_ch.valid <= 1'b0;
    endtask

    // hold the input until every queued result is out and the block is idle
    task automatic drain();
        stop_items();
        while (pending_neighbors.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // register write, only issued after drain
    task automatic write_reg(logic [nntk_pkg::CFG_IDX_W-1:0] idx,
                             logic [nntk_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= data;
        do
            @(posedge clk);
        while (!cfg.ready);
        case (idx)
            nntk_pkg::CFG_DIMS_IN_USE: dims_reg = data[nntk_pkg::DIMS_W-1:0];
            nntk_pkg::CFG_K_IN_USE:    k_reg    = data[nntk_pkg::KCFG_W-1:0];
            default:                   ;
        endcase
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    task automatic setup(int dims_word, int k_word);
        drain();
        write_reg(nntk_pkg::CFG_DIMS_IN_USE, nntk_pkg::CFG_DATA_W'(dims_word));
        write_reg(nntk_pkg::CFG_K_IN_USE, nntk_pkg::CFG_DATA_W'(k_word));
    endtask

    task automatic finish_search();
        send_item(nntk_pkg::ACT_FINISH, nntk_pkg::ELEM_W'($urandom));
    endtask

    // mix of extremes, values close to zero (ties) and full-range noise
    function automatic logic signed [nntk_pkg::ELEM_W-1:0] rand_elem();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            return 16'sh7fff;
        if (roll < 20)
            return 16'sh8000;
        if (roll < 50)
            return nntk_pkg::ELEM_W'($urandom_range(0, 8) - 4);
        return nntk_pkg::ELEM_W'($urandom);
    endfunction

    // ------------------------------------------------------------------
    // directed tests
    // ------------------------------------------------------------------

    // finish with no vector seen, right after reset and after a lone query element
    task automatic test_empty_finish();
        finish_search();
        send_item(nntk_pkg::ACT_QUERY, 16'sd5);
        finish_search();
        finish_search();
    endtask

    // reset settings (64 dims, k 10), opposite extremes give the largest distance;
    // also leaves every query entry written
    task automatic test_widest_distance();
        drain();
        repeat (nntk_pkg::MAX_DIMS_DEF) send_item(nntk_pkg::ACT_QUERY, 16'sh8000);
        repeat (nntk_pkg::MAX_DIMS_DEF) send_item(nntk_pkg::ACT_DATABASE, 16'sh7fff);
        finish_search();
    endtask

    // equal distances, ordering, eviction with k 3, repeated finish
    task automatic test_ties_and_repeat();
        setup(2, 3);
        send_item(nntk_pkg::ACT_QUERY, 16'sd0);
        send_item(nntk_pkg::ACT_QUERY, 16'sd0);
        send_item(nntk_pkg::ACT_DATABASE, 16'sd3);
        send_item(nntk_pkg::ACT_DATABASE, 16'sd4);
        send_item(nntk_pkg::ACT_DATABASE, 16'sd1);
        send_item(nntk_pkg::ACT_DATABASE, 16'sd1);
        send_item(nntk_pkg::ACT_DATABASE, 16'sd0);
        send_item(nntk_pkg::ACT_DATABASE, 16'sd5);
        send_item(nntk_pkg::ACT_DATABASE, 16'sd1);
        send_item(nntk_pkg::ACT_DATABASE, -16'sd1);
        send_item(nntk_pkg::ACT_DATABASE, 16'sd0);
        send_item(nntk_pkg::ACT_DATABASE, 16'sd0);
        finish_search();
        finish_search();
    endtask

    // k lowered after five vectors went into the list, then k 0 and k above the maximum
    task automatic test_k_limits();
        setup(1, 16);
        send_item(nntk_pkg::ACT_QUERY, 16'sd0);
        send_item(nntk_pkg::ACT_DATABASE, 16'sd7);
        send_item(nntk_pkg::ACT_DATABASE, -16'sd2);
        send_item(nntk_pkg::ACT_DATABASE, 16'sd7);
        send_item(nntk_pkg::ACT_DATABASE, 16'sd0);
        send_item(nntk_pkg::ACT_DATABASE, 16'sd3);
        finish_search();
        drain();
        write_reg(nntk_pkg::CFG_K_IN_USE, nntk_pkg::CFG_DATA_W'(2));
        finish_search();
        drain();
        write_reg(nntk_pkg::CFG_K_IN_USE, nntk_pkg::CFG_DATA_W'(0));
        finish_search();
        drain();
        write_reg(nntk_pkg::CFG_K_IN_USE, nntk_pkg::CFG_DATA_W'(31));
        finish_search();
    endtask

    // dims 0 behaves as 1; dims above the maximum behaves as 64 and a
    // partial vector is dropped by finish
    task automatic test_dims_limits();
        setup(0, 4);
        send_item(nntk_pkg::ACT_QUERY, 16'sd100);
        send_item(nntk_pkg::ACT_DATABASE, -16'sd100);
        send_item(nntk_pkg::ACT_DATABASE, 16'sh7fff);
        finish_search();
        setup(127, 4);
        send_item(nntk_pkg::ACT_QUERY, 16'sd9);
        send_item(nntk_pkg::ACT_DATABASE, 16'sd1);
        send_item(nntk_pkg::ACT_DATABASE, 16'sd2);
        finish_search();
    endtask

    // position past a newly lowered dims count closes the vector at the next
    // element; a query element keeps the position
    task automatic test_position_carry();
        setup(4, 5);
        repeat (4) send_item(nntk_pkg::ACT_QUERY, 16'sd1);
        repeat (3) send_item(nntk_pkg::ACT_DATABASE, 16'sd2);
        drain();
        write_reg(nntk_pkg::CFG_DIMS_IN_USE, nntk_pkg::CFG_DATA_W'(2));
        send_item(nntk_pkg::ACT_DATABASE, -16'sd6);
        send_item(nntk_pkg::ACT_DATABASE, 16'sd3);
        send_item(nntk_pkg::ACT_DATABASE, 16'sd3);
        finish_search();
        setup(3, 5);
        send_item(nntk_pkg::ACT_DATABASE, 16'sd4);
        send_item(nntk_pkg::ACT_QUERY, -16'sd7);
        send_item(nntk_pkg::ACT_QUERY, 16'sd2);
        send_item(nntk_pkg::ACT_DATABASE, 16'sd5);
        finish_search();
    endtask

    // unused action leaves no trace; finish mid-vector restarts the position
    task automatic test_ignored_and_partial();
        setup(3, 4);
        send_item(ACT_UNUSED, 16'sh5555);
        repeat (3) send_item(nntk_pkg::ACT_QUERY, 16'sd0);
        send_item(nntk_pkg::ACT_DATABASE, 16'sd1);
        send_item(ACT_UNUSED, -16'sh5556);
        send_item(nntk_pkg::ACT_DATABASE, 16'sd1);
        send_item(nntk_pkg::ACT_DATABASE, 16'sd1);
        send_item(nntk_pkg::ACT_DATABASE, 16'sd9);
        send_item(nntk_pkg::ACT_DATABASE, 16'sd9);
        finish_search();
        repeat (3) send_item(nntk_pkg::ACT_DATABASE, 16'sd2);
        finish_search();
    endtask

    // ------------------------------------------------------------------
    // random searches
    // ------------------------------------------------------------------

    // one search: fresh settings, usually a new query, some vectors, finish;
    // a fifth of searches carry stray and broken items
    task automatic run_search_episode();
        logic signed [nntk_pkg::ELEM_W-1:0] prev_vec [nntk_pkg::MAX_DIMS_DEF];
        int  roll;
        int  d;
        int  kv;
        int  nvec;
        bit  noisy;
        bit  have_prev;
        d         = $urandom_range(1, 5);
        kv        = $urandom_range(0, 20);
        nvec      = $urandom_range(0, 8);
        noisy     = ($urandom_range(0, 4) == 0);
        have_prev = 1'b0;
        setup(d, kv);
        if ($urandom_range(0, 99) < 80)
            repeat (d) send_item(nntk_pkg::ACT_QUERY, rand_elem());
        for (int v = 0; v < nvec; v++)
        begin
            // a repeated vector gives an exact tie
            roll = $urandom_range(0, 99);
            for (int e = 0; e < d; e++)
            begin
                if (!(have_prev && roll < 25))
                    prev_vec[e] = rand_elem();
                send_item(nntk_pkg::ACT_DATABASE, prev_vec[e]);
                if (noisy && $urandom_range(0, 9) == 0)
                    send_item(ACT_UNUSED, rand_elem());
            end
            have_prev = 1'b1;
        end
        // broken vector left open for finish to drop
        if (noisy)
            repeat ($urandom_range(0, d - 1))
                send_item(nntk_pkg::ACT_DATABASE, rand_elem());
        finish_search();
        if ($urandom_range(0, 3) == 0)
            finish_search();
    endtask

    task automatic run_random_phase(int send_pct, int recv_pct, int target);
        int start_count;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        start_count   = items_sent;
        while (items_sent - start_count < target)
            run_search_episode();
    endtask

    // ------------------------------------------------------------------
    // sequence of the run
    // ------------------------------------------------------------------
    initial
    begin
        in_ch.valid         = 1'b0;
        in_ch.action        = nntk_pkg::ACT_QUERY;
        in_ch.element_value = '0;
        cfg.valid           = 1'b0;
        cfg.index           = nntk_pkg::CFG_DIMS_IN_USE;
        cfg.data            = '0;
        dims_reg            = nntk_pkg::DIMS_W'(nntk_pkg::MAX_DIMS_DEF);
        k_reg               = nntk_pkg::KCFG_W'(10);
        elem_pos            = '0;
        dist_sum            = '0;
        vec_count           = '0;
        top_fill            = '0;
        rst_n               = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part under sender 26 / receiver 61 percent idling
        send_idle_pct = 26;
        recv_idle_pct = 61;
        test_empty_finish();
        test_widest_distance();
        test_ties_and_repeat();
        test_k_limits();
        test_dims_limits();
        test_position_carry();
        test_ignored_and_partial();

        run_random_phase(26, 61, 85);
        run_random_phase(61, 26, 85);
        run_random_phase(0, 0, 75);

        drain();
        if (failures == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
